[rtl/sbg_pkg.sv]
// ----------------------------------------------------------------------------
// sbg_pkg
// shared types and constants of the spectrum bar-graph pixel generator
// ----------------------------------------------------------------------------
package sbg_pkg;

  localparam int unsigned NumLevels = 19;
  localparam int unsigned LevelW    = 5;

  // smallest raw q28.4 magnitude that gives level k+1
  localparam logic [31:0] LevelThr [NumLevels] = '{
    32'd26, 32'd64, 32'd160, 32'd402, 32'd1010, 32'd2536, 32'd6370, 32'd16000,
    32'd40191, 32'd100954, 32'd253583, 32'd636972, 32'd1600000, 32'd4019019,
    32'd10095318, 32'd25358292, 32'd63697148, 32'd160000000, 32'd401901830
  };

  // effect codes
  localparam logic [2:0] EffRainbow    = 3'd0;
  localparam logic [2:0] EffFixed      = 3'd1;
  localparam logic [2:0] EffMoving     = 3'd2;
  localparam logic [2:0] EffDotRainbow = 3'd3;
  localparam logic [2:0] EffDotFixed   = 3'd4;

  // rainbow hue ramp
  localparam int unsigned HueStart = 36;
  localparam int unsigned HueStep  = 5;

  // register reset values
  localparam logic [31:0] RstSwitchPeriod = 32'd60000;
  localparam logic [15:0] RstHuePeriod    = 16'd20;
  localparam logic [2:0]  RstLastEffect   = 3'd2;
  localparam logic [7:0]  RstFixedHue     = 8'd250;
  localparam logic [7:0]  RstFixedSat     = 8'd100;
  localparam logic [7:0]  RstFixedVal     = 8'd100;
  localparam logic [7:0]  RstRainbowSat   = 8'd230;
  localparam logic [7:0]  RstRainbowVal   = 8'd240;

  typedef enum logic [2:0] {
    CFG_SWITCH_PERIOD,
    CFG_HUE_PERIOD,
    CFG_LAST_EFFECT,
    CFG_FIXED_HUE,
    CFG_FIXED_SAT,
    CFG_FIXED_VAL,
    CFG_RAINBOW_SAT,
    CFG_RAINBOW_VAL
  } cfg_idx_e;

  // one column to draw, as classified by the front end
  typedef struct packed {
    logic [8:0]        led_base;  // strip index of row 0
    logic [7:0]        hue;       // hue of row 0
    logic              ramp;      // hue steps along the rows
    logic              dot;       // single dot instead of a bar
    logic [LevelW-1:0] level;
    logic [7:0]        sat;
    logic [7:0]        val;
  } cmd_t;

endpackage

[rtl/sbg_if.sv]
// ----------------------------------------------------------------------------
// sbg channel interfaces
// valid/ready channels for input items, pixel items and register writes
// ----------------------------------------------------------------------------
interface sbg_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [3:0]  column;
  logic [31:0] magnitude;
  modport source (output valid, func, column, magnitude, input ready);
  modport sink   (input valid, func, column, magnitude, output ready);
endinterface

interface sbg_out_if;
  logic       valid;
  logic       ready;
  logic [8:0] led_index;
  logic       lit;
  logic [7:0] hue;
  logic [7:0] sat;
  logic [7:0] bright;
  logic       last;
  modport source (output valid, led_index, lit, hue, sat, bright, last, input ready);
  modport sink   (input valid, led_index, lit, hue, sat, bright, last, output ready);
endinterface

interface sbg_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[rtl/sbg_front.sv]
// ----------------------------------------------------------------------------
// sbg_front
// accepts items: runs millisecond ticks, turns columns into draw commands
// ----------------------------------------------------------------------------
module sbg_front #(
  parameter int unsigned COLUMNS = 15,
  parameter int unsigned ROWS    = 20
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  sbg_in_if.sink        in_i,
  sbg_cfg_if.sink       cfg_i,
  input  logic          full_i,
  output logic          push_o,
  output sbg_pkg::cmd_t cmd_o
);
  import sbg_pkg::*;

  logic [31:0] switch_period_q, switch_period_d;
  logic [15:0] hue_period_q, hue_period_d;
  logic [2:0]  last_effect_q, last_effect_d;
  logic [7:0]  fixed_hue_q, fixed_hue_d, fixed_sat_q, fixed_sat_d;
  logic [7:0]  fixed_val_q, fixed_val_d;
  logic [7:0]  rainbow_sat_q, rainbow_sat_d, rainbow_val_q, rainbow_val_d;

  logic [31:0] ms_count_q, ms_count_d;
  logic [31:0] switch_stamp_q, switch_stamp_d;
  logic [31:0] hue_stamp_q, hue_stamp_d;
  logic [2:0]  effect_q, effect_d;
  logic [7:0]  moving_hue_q, moving_hue_d;

  logic           accept;
  logic [31:0]    ms_next;
  logic           switch_fire;
  logic [3:0]     effect_inc;
  logic [2:0]     effect_new;
  logic           hue_fire;
  logic [NumLevels-1:0] above;
  logic [10:0]    base_full;
  logic [12:0]    ramp_full;
  logic           is_rainbow, is_moving;

  assign in_i.ready  = !full_i;
  assign cfg_i.ready = 1'b1;
  assign accept      = in_i.valid && in_i.ready;

  // register writes
  always_comb begin
    switch_period_d = switch_period_q;
    hue_period_d    = hue_period_q;
    last_effect_d   = last_effect_q;
    fixed_hue_d     = fixed_hue_q;
    fixed_sat_d     = fixed_sat_q;
    fixed_val_d     = fixed_val_q;
    rainbow_sat_d   = rainbow_sat_q;
    rainbow_val_d   = rainbow_val_q;
    if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.index))
        CFG_SWITCH_PERIOD: switch_period_d = cfg_i.data;
        CFG_HUE_PERIOD:    hue_period_d    = cfg_i.data[15:0];
        CFG_LAST_EFFECT:   last_effect_d   = cfg_i.data[2:0];
        CFG_FIXED_HUE:     fixed_hue_d     = cfg_i.data[7:0];
        CFG_FIXED_SAT:     fixed_sat_d     = cfg_i.data[7:0];
        CFG_FIXED_VAL:     fixed_val_d     = cfg_i.data[7:0];
        CFG_RAINBOW_SAT:   rainbow_sat_d   = cfg_i.data[7:0];
        CFG_RAINBOW_VAL:   rainbow_val_d   = cfg_i.data[7:0];
        default: ;
      endcase
    end
  end

  // millisecond tick
  assign ms_next     = ms_count_q + 32'd1;
  assign switch_fire = (ms_next - switch_stamp_q) > switch_period_q;
  assign effect_inc  = {1'b0, effect_q} + 4'd1;
  always_comb begin
    effect_new = effect_q;
    if (switch_fire) begin
      effect_new = (effect_inc > {1'b0, last_effect_q}) ? EffRainbow : effect_inc[2:0];
    end
  end
  assign hue_fire = (effect_new == EffMoving) &&
                    ((ms_next - hue_stamp_q) > {16'd0, hue_period_q});

  always_comb begin
    ms_count_d     = ms_count_q;
    switch_stamp_d = switch_stamp_q;
    hue_stamp_d    = hue_stamp_q;
    effect_d       = effect_q;
    moving_hue_d   = moving_hue_q;
    if (accept && !in_i.func) begin
      ms_count_d = ms_next;
      effect_d   = effect_new;
      if (switch_fire) begin
        switch_stamp_d = ms_next;
      end
      if (hue_fire) begin
        hue_stamp_d  = ms_next;
        moving_hue_d = moving_hue_q + 8'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      switch_period_q <= RstSwitchPeriod;
      hue_period_q    <= RstHuePeriod;
      last_effect_q   <= RstLastEffect;
      fixed_hue_q     <= RstFixedHue;
      fixed_sat_q     <= RstFixedSat;
      fixed_val_q     <= RstFixedVal;
      rainbow_sat_q   <= RstRainbowSat;
      rainbow_val_q   <= RstRainbowVal;
      ms_count_q      <= '0;
      switch_stamp_q  <= '0;
      hue_stamp_q     <= '0;
      effect_q        <= EffFixed;
      moving_hue_q    <= '0;
    end else begin
      switch_period_q <= switch_period_d;
      hue_period_q    <= hue_period_d;
      last_effect_q   <= last_effect_d;
      fixed_hue_q     <= fixed_hue_d;
      fixed_sat_q     <= fixed_sat_d;
      fixed_val_q     <= fixed_val_d;
      rainbow_sat_q   <= rainbow_sat_d;
      rainbow_val_q   <= rainbow_val_d;
      ms_count_q      <= ms_count_d;
      switch_stamp_q  <= switch_stamp_d;
      hue_stamp_q     <= hue_stamp_d;
      effect_q        <= effect_d;
      moving_hue_q    <= moving_hue_d;
    end
  end

  // column classification: level by threshold compare, thresholds ascend
  always_comb begin
    for (int k = 0; k < NumLevels; k++) begin
      above[k] = in_i.magnitude >= LevelThr[k];
    end
  end

  assign base_full  = 11'((11'(COLUMNS - 1) - 11'(in_i.column)) * 11'(ROWS));
  assign ramp_full  = 13'(13'(in_i.column) * 13'(ROWS * HueStep) + 13'(HueStart));
  assign is_rainbow = (effect_q == EffRainbow) || (effect_q == EffDotRainbow);
  assign is_moving  = (effect_q == EffMoving);

  always_comb begin
    cmd_o.led_base = base_full[8:0];
    cmd_o.ramp     = is_rainbow;
    cmd_o.dot      = (effect_q == EffDotRainbow) || (effect_q == EffDotFixed);
    cmd_o.level    = LevelW'($countones(above));
    if (is_rainbow) begin
      cmd_o.hue = ramp_full[7:0];
    end else if (is_moving) begin
      cmd_o.hue = moving_hue_q;
    end else begin
      cmd_o.hue = fixed_hue_q;
    end
    cmd_o.sat = (is_rainbow || is_moving) ? rainbow_sat_q : fixed_sat_q;
    cmd_o.val = (is_rainbow || is_moving) ? rainbow_val_q : fixed_val_q;
  end

  // columns past the strip are dropped
  assign push_o = accept && in_i.func && (32'(in_i.column) < 32'(COLUMNS));

endmodule

[rtl/sbg_fifo.sv]
// ----------------------------------------------------------------------------
// sbg_fifo
// short command queue between front end and pixel back end
// ----------------------------------------------------------------------------
module sbg_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  sbg_pkg::cmd_t data_i,
  input  logic          pop_i,
  output sbg_pkg::cmd_t data_o,
  output logic          full_o,
  output logic          empty_o
);
  import sbg_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

[rtl/sbg_back.sv]
// ----------------------------------------------------------------------------
// sbg_back
// walks the rows of the head command, one pixel item a cycle while out_o is ready
// ----------------------------------------------------------------------------
module sbg_back #(
  parameter int unsigned ROWS = 20
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  sbg_pkg::cmd_t cmd_i,
  input  logic          empty_i,
  output logic          pop_o,
  sbg_out_if.source     out_o
);
  import sbg_pkg::*;

  localparam int unsigned RowW = $clog2(ROWS);

  logic [RowW-1:0] row_q, row_d;
  logic            valid_q, valid_d;
  logic [8:0]      led_index_q, led_index_d;
  logic            lit_q, lit_d, last_q, last_d;
  logic [7:0]      hue_q, hue_d, sat_q, sat_d, bright_q, bright_d;
  logic            advance, fire, row_last;

  assign advance  = !valid_q || out_o.ready;
  assign fire     = advance && !empty_i;
  assign row_last = (row_q == RowW'(ROWS - 1));
  assign pop_o    = fire && row_last;

  always_comb begin
    row_d       = row_q;
    valid_d     = valid_q;
    led_index_d = led_index_q;
    lit_d       = lit_q;
    last_d      = last_q;
    hue_d       = hue_q;
    sat_d       = sat_q;
    bright_d    = bright_q;
    if (fire) begin
      row_d       = row_last ? '0 : row_q + RowW'(1);
      valid_d     = 1'b1;
      led_index_d = cmd_i.led_base + 9'(row_q);
      lit_d       = cmd_i.dot ? (32'(row_q) == 32'(cmd_i.level))
                              : (32'(row_q) <= 32'(cmd_i.level));
      last_d      = row_last;
      hue_d       = cmd_i.ramp ? cmd_i.hue + 8'(8'(row_q) * 8'(HueStep)) : cmd_i.hue;
      sat_d       = cmd_i.sat;
      bright_d    = cmd_i.val;
    end else if (out_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      row_q   <= row_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    led_index_q <= led_index_d;
    lit_q       <= lit_d;
    last_q      <= last_d;
    hue_q       <= hue_d;
    sat_q       <= sat_d;
    bright_q    <= bright_d;
  end

  assign out_o.valid     = valid_q;
  assign out_o.led_index = led_index_q;
  assign out_o.lit       = lit_q;
  assign out_o.last      = last_q;
  assign out_o.hue       = hue_q;
  assign out_o.sat       = sat_q;
  assign out_o.bright    = bright_q;

endmodule

[rtl/spectrum_bar_graph_pixels.sv]
// ----------------------------------------------------------------------------
// spectrum_bar_graph_pixels
// bar-graph led frame generator: column magnitudes in, pixel items out
// ----------------------------------------------------------------------------
// channels:
//   in_i  : func 0 is a millisecond tick, func 1 a q28.4 column magnitude
//   cfg_i : register writes (index, data), always ready, write while idle
//   out_o : one pixel item per row, rows 0..ROWS-1, last set on the final row
// a tick updates the effect rotation and the moving hue; it gives no pixel
// items. a column is turned into a draw command (level from a threshold
// compare, colour of the current effect) in the cycle it is accepted and
// queued in a two-entry command queue.
// with the back end idle, an accepted column passes through the command
// queue and the pixel register before its first pixel is valid.
// throughput: the back end emits one pixel a cycle while out_o is ready;
// columns follow each other with no gap, ticks one a cycle while in_i.ready.
// a column index of COLUMNS or more is accepted and dropped.
// reset loads the register defaults and starts at effect 1 with all counters
// clear. when out_o stalls the pixel register holds and the queue fills; once
// it is full in_i.ready drops.
// ----------------------------------------------------------------------------
module spectrum_bar_graph_pixels #(
  parameter int unsigned COLUMNS = 15,
  parameter int unsigned ROWS    = 20
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sbg_in_if.sink     in_i,
  sbg_cfg_if.sink    cfg_i,
  sbg_out_if.source  out_o
);
  import sbg_pkg::*;

  // front end to queue
  cmd_t front_cmd;
  logic fifo_push;
  logic fifo_full;

  // queue to back end
  cmd_t head_cmd;
  logic fifo_pop;
  logic fifo_empty;

  sbg_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .cfg_i  (cfg_i),
    .full_i (fifo_full),
    .push_o (fifo_push),
    .cmd_o  (front_cmd)
  );

  // two entries let the front classify the next column while one draws
  sbg_fifo #(
    .Depth (2)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fifo_push),
    .data_i  (front_cmd),
    .pop_i   (fifo_pop),
    .data_o  (head_cmd),
    .full_o  (fifo_full),
    .empty_o (fifo_empty)
  );

  sbg_back #(
    .ROWS (ROWS)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (head_cmd),
    .empty_i (fifo_empty),
    .pop_o   (fifo_pop),
    .out_o   (out_o)
  );

  // no command is lost to a full queue
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_push |-> !fifo_full)
    else $error("command pushed into full queue");

  // the back end retires only commands that exist
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_pop |-> !fifo_empty)
    else $error("command popped from empty queue");

  // retiring a command puts its final row on the output
  a_pop_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_pop |=> (out_o.valid && out_o.last))
    else $error("final row missing after command retire");

  // a column can be accepted only with room in the queue
  a_ready_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> !fifo_full)
    else $error("input ready while queue full");

endmodule
